/* rtl/frh_pkg.sv */
// ----------------------------------------------------------------------------
// frh_pkg: shared types and constants for the fixed-range histogram
// Holds the queue word, the back-end state encoding, opcode and register
// codes, and the helper that clamps a count to the 32-bit report width.
// ----------------------------------------------------------------------------
package frh_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_BITS    = 32;
    localparam int SELECT_BITS    = 16;
    localparam int REPORT_BITS    = 32;
    localparam int CFG_INDEX_BITS = 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // Opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH = 1'b1;

    // Classified word passed from front to back
    typedef struct packed {
        logic                   op;
        logic                   keep;    // add sample lies inside the range
        logic [SAMPLE_BITS-1:0] off;     // sample minus range low
        logic [SELECT_BITS-1:0] sel;
    } entry_t;

    // Status from back to front
    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_DIVIDE,
        BK_LOOKUP
    } back_state_t;

    // Clamp a count (zero-extended to 64 bits) to the report width
    function automatic logic [REPORT_BITS-1:0] report32(input logic [63:0] c);
        logic [REPORT_BITS-1:0] r;
        r = (|c[63:REPORT_BITS]) ? '1 : c[REPORT_BITS-1:0];
        return r;
    endfunction

endpackage

/* rtl/frh_front.sv */
// ----------------------------------------------------------------------------
// frh_front: input side of the histogram
// Accepts words, checks add samples against the configured range, forms the
// offset from range low and holds classified words in a two-entry queue.
// ----------------------------------------------------------------------------
module frh_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 opcode,
    input  logic signed [frh_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [frh_pkg::SELECT_BITS-1:0]      bin_select,
    input  logic signed [frh_pkg::SAMPLE_BITS-1:0] range_low,
    input  logic signed [frh_pkg::SAMPLE_BITS-1:0] range_high,
    input  frh_pkg::back_status_t                status,
    output frh_pkg::entry_t                      entry,
    output logic                                 entry_valid,
    input  logic                                 entry_ready
);

    frh_pkg::entry_t                   slot_reg [frh_pkg::QUEUE_DEPTH];
    logic [frh_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [frh_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [frh_pkg::QCNT_BITS-1:0]     count_reg;
    logic [frh_pkg::QCNT_BITS-1:0]     count_next;
    frh_pkg::entry_t                   new_entry;
    logic signed [frh_pkg::SAMPLE_BITS:0] diff;
    logic                              in_range;
    logic                              do_push;
    logic                              do_pop;

    // Classify the incoming word
    always_comb
    begin
        diff     = {sample[frh_pkg::SAMPLE_BITS-1], sample}
                 - {range_low[frh_pkg::SAMPLE_BITS-1], range_low};
        in_range = (range_high > range_low) && (sample >= range_low)
                && (sample < range_high);
        new_entry.op   = opcode;
        new_entry.keep = in_range;
        new_entry.off  = diff[frh_pkg::SAMPLE_BITS-1:0];
        new_entry.sel  = bin_select;
    end

    // Queue handshakes; hold off input while the store is being cleared
    assign full        = (count_reg == frh_pkg::QCNT_BITS'(frh_pkg::QUEUE_DEPTH))
                      || status.clearing;
    assign do_push     = push && !full;
    assign entry_valid = (count_reg != '0);
    assign do_pop      = entry_valid && entry_ready;
    assign entry       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the classified word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

/* rtl/frh_div.sv */
// ----------------------------------------------------------------------------
// frh_div: bin index divider
// Computes floor(off * BIN_COUNT / span) for off < span with a restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frh_div #(
    parameter int BIN_COUNT = 1024,
    parameter int QUOT_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [frh_pkg::SAMPLE_BITS-1:0]   off,
    input  logic [frh_pkg::SAMPLE_BITS-1:0]   span,
    output logic                              done,
    output logic [QUOT_BITS-1:0]              quot
);

    localparam int NUM_BITS = frh_pkg::SAMPLE_BITS + QUOT_BITS;
    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

    logic                              busy_reg;
    logic [CNT_BITS-1:0]               cnt_reg;
    logic [frh_pkg::SAMPLE_BITS-1:0]   rem_reg;
    logic [QUOT_BITS-1:0]              shift_reg;
    logic [NUM_BITS-1:0]               product;
    logic [frh_pkg::SAMPLE_BITS:0]     rem_wide;
    logic                              ge;
    logic [frh_pkg::SAMPLE_BITS:0]     rem_sub;

    // Scale the offset by the bin count
    assign product = NUM_BITS'(off) * NUM_BITS'(BIN_COUNT);

    // One restoring step: shift in the next numerator bit, try the subtract
    always_comb
    begin
        rem_wide = {rem_reg, shift_reg[QUOT_BITS-1]};
        ge       = (rem_wide >= {1'b0, span});
        rem_sub  = rem_wide - {1'b0, span};
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quot = shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(QUOT_BITS);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= product[NUM_BITS-1:QUOT_BITS];
            shift_reg <= product[QUOT_BITS-1:0];
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg   <= ge ? rem_sub[frh_pkg::SAMPLE_BITS-1:0]
                            : rem_wide[frh_pkg::SAMPLE_BITS-1:0];
            shift_reg <= QUOT_BITS'({shift_reg, ge});
        end
    end

endmodule

/* rtl/frh_back.sv */
// ----------------------------------------------------------------------------
// frh_back: execution side of the histogram
// Clears the count store after reset, then takes one queued word at a time:
// an add divides to find the bin and reads and updates the count, a read
// reads the selected count, and every word loads the result register.
// ----------------------------------------------------------------------------
module frh_back #(
    parameter int BIN_COUNT  = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [frh_pkg::SAMPLE_BITS-1:0] range_low,
    input  logic signed [frh_pkg::SAMPLE_BITS-1:0] range_high,
    input  frh_pkg::entry_t                        entry,
    input  logic                                   entry_valid,
    output logic                                   entry_ready,
    output frh_pkg::back_status_t                  status,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   sample_counted,
    output logic [frh_pkg::SELECT_BITS-1:0]        bin_hit,
    output logic                                   read_valid,
    output logic [frh_pkg::REPORT_BITS-1:0]        bin_value,
    output logic [frh_pkg::REPORT_BITS-1:0]        total_counted
);

    localparam int ADDR_BITS = $clog2(BIN_COUNT);

    // Count store
    logic [COUNT_BITS-1:0] mem [BIN_COUNT];

    frh_pkg::back_state_t              state_reg;
    frh_pkg::back_state_t              state_next;
    logic [ADDR_BITS-1:0]              clr_addr_reg;
    logic                              op_reg;
    logic [frh_pkg::SELECT_BITS-1:0]   hit_reg;
    logic [frh_pkg::SELECT_BITS-1:0]   hit_next;
    logic                              hit_load;
    logic [COUNT_BITS-1:0]             rd_data_reg;
    logic [COUNT_BITS-1:0]             total_reg;
    logic [COUNT_BITS-1:0]             total_bump;
    logic [COUNT_BITS-1:0]             bin_bump;
    logic                              out_valid_reg;
    logic                              out_free;
    logic                              take;
    logic                              sel_ok;
    logic                              div_start;
    logic                              div_done;
    logic [ADDR_BITS-1:0]              div_quot;
    logic [frh_pkg::SAMPLE_BITS-1:0]   span;
    logic                              rd_en;
    logic [ADDR_BITS-1:0]              rd_addr;
    logic                              wr_en;
    logic [ADDR_BITS-1:0]              wr_addr;
    logic [COUNT_BITS-1:0]             wr_data;
    logic                              total_inc;
    logic                              res_push;
    logic                              res_counted;
    logic [frh_pkg::SELECT_BITS-1:0]   res_hit;
    logic                              res_valid;
    logic [frh_pkg::REPORT_BITS-1:0]   res_value;
    logic [frh_pkg::REPORT_BITS-1:0]   res_total;

    assign span = range_high - range_low;

    frh_div #(
        .BIN_COUNT (BIN_COUNT),
        .QUOT_BITS (ADDR_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .off   (entry.off),
        .span  (span),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Saturating increments
    assign total_bump = (total_reg == '1) ? total_reg : total_reg + 1'b1;
    assign bin_bump   = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;

    assign out_free        = !out_valid_reg || pop;
    assign entry_ready     = (state_reg == frh_pkg::BK_IDLE) && out_free;
    assign take            = entry_valid && entry_ready;
    assign sel_ok          = ({1'b0, entry.sel} < (frh_pkg::SELECT_BITS + 1)'(BIN_COUNT));
    assign status.clearing = (state_reg == frh_pkg::BK_CLEAR);

    // Sequence one word: next state, store accesses and result
    always_comb
    begin
        state_next  = state_reg;
        div_start   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = div_quot;
        wr_en       = 1'b0;
        wr_addr     = clr_addr_reg;
        wr_data     = '0;
        total_inc   = 1'b0;
        hit_load    = 1'b0;
        hit_next    = hit_reg;
        res_push    = 1'b0;
        res_counted = 1'b0;
        res_hit     = '0;
        res_valid   = 1'b0;
        res_value   = '0;
        res_total   = frh_pkg::report32(64'(total_reg));
        case (state_reg)
            frh_pkg::BK_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_addr_reg == ADDR_BITS'(BIN_COUNT - 1))
                begin
                    state_next = frh_pkg::BK_IDLE;
                end
            end
            frh_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    if (entry.op == frh_pkg::OP_ADD)
                    begin
                        if (entry.keep)
                        begin
                            div_start  = 1'b1;
                            state_next = frh_pkg::BK_DIVIDE;
                        end
                        else
                        begin
                            // Dropped sample
                            res_push = 1'b1;
                        end
                    end
                    else if (sel_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = entry.sel[ADDR_BITS-1:0];
                        hit_load   = 1'b1;
                        hit_next   = entry.sel;
                        state_next = frh_pkg::BK_LOOKUP;
                    end
                    else
                    begin
                        // Read beyond the last bin
                        res_push = 1'b1;
                        res_hit  = entry.sel;
                    end
                end
            end
            frh_pkg::BK_DIVIDE:
            begin
                if (div_done)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = div_quot;
                    hit_load   = 1'b1;
                    hit_next   = frh_pkg::SELECT_BITS'(div_quot);
                    state_next = frh_pkg::BK_LOOKUP;
                end
            end
            frh_pkg::BK_LOOKUP:
            begin
                res_push   = 1'b1;
                res_hit    = hit_reg;
                state_next = frh_pkg::BK_IDLE;
                if (op_reg == frh_pkg::OP_ADD)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = hit_reg[ADDR_BITS-1:0];
                    wr_data     = bin_bump;
                    total_inc   = 1'b1;
                    res_counted = 1'b1;
                    res_total   = frh_pkg::report32(64'(total_bump));
                end
                else
                begin
                    res_valid = 1'b1;
                    res_value = frh_pkg::report32(64'(rd_data_reg));
                end
            end
            default:
            begin
                state_next = frh_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frh_pkg::BK_CLEAR;
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == frh_pkg::BK_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (total_inc)
            begin
                total_reg <= total_bump;
            end
            if (res_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the word's opcode, bin and result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= entry.op;
        end
        if (hit_load)
        begin
            hit_reg <= hit_next;
        end
        if (res_push)
        begin
            sample_counted <= res_counted;
            bin_hit        <= res_hit;
            read_valid     <= res_valid;
            bin_value      <= res_value;
            total_counted  <= res_total;
        end
    end

    // Count store ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign empty = !out_valid_reg;

    // A result never lands on a word that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!out_valid_reg || pop))
        else $error("result register overwritten");

    // The divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == frh_pkg::BK_DIVIDE))
        else $error("divider done outside divide state");

    // No word is taken before the store is cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frh_pkg::BK_CLEAR) |-> (!take && !rd_en))
        else $error("store accessed during clear");

    // The total never goes down
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("total count decreased");

endmodule

/* rtl/fixed_range_histogram.sv */
// ----------------------------------------------------------------------------
// fixed_range_histogram: uniform-bin histogram over a configured range
// Adds Q16.16 samples into BIN_COUNT saturating bins between range_low and
// range_high, or reads back one bin; every word reports the running total.
//
//   Channel   Handshake          Words carried
//   input     push / full        opcode, sample, bin_select
//   result    pop / empty        sample_counted, bin_hit, read_valid,
//                                bin_value, total_counted
//   config    cfg_valid/ready    cfg_index, cfg_data (0 = low, 1 = high)
//
// Back end: an in-range add runs the divider (one quotient bit per cycle),
// then one store read and one update; a read does one store read, and a
// dropped sample or out-of-range read goes straight to the result register.
// Reset: the count store is swept to zero; full stays high until the sweep
// ends. Config writes are taken at any time.
// Stalls: a two-word queue and the result register let input and result
// sides stall independently.
// ----------------------------------------------------------------------------
module fixed_range_histogram #(
    parameter int BIN_COUNT  = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input words
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   opcode,
    input  logic signed [frh_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [frh_pkg::SELECT_BITS-1:0]        bin_select,
    // result words
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   sample_counted,
    output logic [frh_pkg::SELECT_BITS-1:0]        bin_hit,
    output logic                                   read_valid,
    output logic [frh_pkg::REPORT_BITS-1:0]        bin_value,
    output logic [frh_pkg::REPORT_BITS-1:0]        total_counted,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [frh_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [frh_pkg::SAMPLE_BITS-1:0]        cfg_data
);

    logic signed [frh_pkg::SAMPLE_BITS-1:0] range_low_reg;
    logic signed [frh_pkg::SAMPLE_BITS-1:0] range_high_reg;
    frh_pkg::entry_t                        entry;
    logic                                   entry_valid;
    logic                                   entry_ready;
    frh_pkg::back_status_t                  status;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= 32'sd0;
            range_high_reg <= 32'sd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                frh_pkg::REG_RANGE_LOW:  range_low_reg  <= $signed(cfg_data);
                frh_pkg::REG_RANGE_HIGH: range_high_reg <= $signed(cfg_data);
                default:                 range_low_reg  <= range_low_reg;
            endcase
        end
    end

    frh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .sample      (sample),
        .bin_select  (bin_select),
        .range_low   (range_low_reg),
        .range_high  (range_high_reg),
        .status      (status),
        .entry       (entry),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready)
    );

    frh_back #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .range_low      (range_low_reg),
        .range_high     (range_high_reg),
        .entry          (entry),
        .entry_valid    (entry_valid),
        .entry_ready    (entry_ready),
        .status         (status),
        .empty          (empty),
        .pop            (pop),
        .sample_counted (sample_counted),
        .bin_hit        (bin_hit),
        .read_valid     (read_valid),
        .bin_value      (bin_value),
        .total_counted  (total_counted)
    );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the fixed-range histogram
// Adds and reads words against a bin-tally predictor. The bench writes the
// range registers between phases, sends bursty input traffic, applies
// receiver back-pressure, and checks every result word field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     TB_BINS       = 1024;
    localparam int     TB_COUNT_BITS = 32;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     TAIL_CYCLES   = 40;
    localparam int     RAND_PHASES   = 6;
    localparam int     PHASE_WORDS   = 72;
    localparam int     HOLD_CYCLES   = 64;
    localparam longint Q_MIN         = -64'sh8000_0000;
    localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - TB_COUNT_BITS);

    typedef struct packed {
        logic                            op;
        logic [frh_pkg::SAMPLE_BITS-1:0] sample;
        logic [frh_pkg::SELECT_BITS-1:0] sel;
    } hist_word_t;

    typedef struct packed {
        logic                            counted;
        logic [frh_pkg::SELECT_BITS-1:0] bin;
        logic                            valid;
        logic [frh_pkg::REPORT_BITS-1:0] value;
        logic [frh_pkg::REPORT_BITS-1:0] total;
    } hist_result_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic opcode;
    logic [frh_pkg::SAMPLE_BITS-1:0] sample;
    logic [frh_pkg::SELECT_BITS-1:0] bin_select;
    logic empty;
    logic pop;
    logic sample_counted;
    logic [frh_pkg::SELECT_BITS-1:0] bin_hit;
    logic read_valid;
    logic [frh_pkg::REPORT_BITS-1:0] bin_value;
    logic [frh_pkg::REPORT_BITS-1:0] total_counted;
    logic cfg_valid;
    logic cfg_ready;
    logic [frh_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [frh_pkg::SAMPLE_BITS-1:0] cfg_data;

    // Predictor state: range edges and bin tallies
    longint      lo_edge;
    longint      hi_edge;
    logic [63:0] tally [TB_BINS];
    logic [63:0] tally_total;

    hist_word_t   stim_words[$];
    hist_result_t due_results[$];
    hist_result_t want;

    int errors;
    int n_add;
    int n_drop;
    int n_read;
    int n_bad_read;
    int n_checked;
    int n_full_stalls;
    int n_holds;
    int n_cfg_writes;
    int cycle_count;

    int burst_left;
    int gap_left;
    int hold_left;
    int next_hold_at;
    int rx_mode;
    int rx_tick;
    logic rx_holding;

    fixed_range_histogram #(
        .BIN_COUNT  (TB_BINS),
        .COUNT_BITS (TB_COUNT_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .sample         (sample),
        .bin_select     (bin_select),
        .empty          (empty),
        .pop            (pop),
        .sample_counted (sample_counted),
        .bin_hit        (bin_hit),
        .read_valid     (read_valid),
        .bin_value      (bin_value),
        .total_counted  (total_counted),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Saturating increment at the count width
    function automatic logic [63:0] sat_inc(input logic [63:0] c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + 64'd1;
    endfunction

    // Clamp a count to the reported width
    function automatic logic [frh_pkg::REPORT_BITS-1:0] clamp_report(input logic [63:0] c);
        return (c > 64'hFFFF_FFFF) ? '1 : c[frh_pkg::REPORT_BITS-1:0];
    endfunction

    // Apply one word to the tallies and return the result it produces
    function automatic hist_result_t tally_word(input hist_word_t w);
        hist_result_t r;
        longint       x;
        logic [63:0]  span;
        logic [63:0]  off;
        logic [63:0]  bin;
        r = '0;
        if (w.op == frh_pkg::OP_ADD)
        begin
            n_add++;
            x = {{32{w.sample[frh_pkg::SAMPLE_BITS-1]}}, w.sample};
            if (hi_edge > lo_edge && x >= lo_edge && x < hi_edge)
            begin
                span = hi_edge - lo_edge;
                off  = x - lo_edge;
                bin  = off * TB_BINS / span;
                if (bin < TB_BINS)
                begin
                    tally[bin]  = sat_inc(tally[bin]);
                    tally_total = sat_inc(tally_total);
                    r.counted   = 1'b1;
                    r.bin       = bin[frh_pkg::SELECT_BITS-1:0];
                end
            end
            if (!r.counted)
                n_drop++;
        end
        else
        begin
            n_read++;
            r.bin = w.sel;
            if (w.sel < TB_BINS)
            begin
                r.valid = 1'b1;
                r.value = clamp_report(tally[w.sel]);
            end
            else
                n_bad_read++;
        end
        r.total = clamp_report(tally_total);
        return r;
    endfunction

    // Driver: offer queued words in bursts, hold a word until it is taken
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            due_results.push_back(tally_word(stim_words[0]));
            void'(stim_words.pop_front());
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        if (rst_n && push && full)
            n_full_stalls++;
        if (rx_holding)
            gap_left = 0;
        if (gap_left > 0)
        begin
            gap_left--;
            push       <= 1'b0;
            opcode     <= 1'($urandom_range(0, 1));
            sample     <= $urandom();
            bin_select <= 16'($urandom());
        end
        else if (stim_words.size() != 0)
        begin
            push       <= 1'b1;
            opcode     <= stim_words[0].op;
            sample     <= stim_words[0].sample;
            bin_select <= stim_words[0].sel;
        end
        else
        begin
            push       <= 1'b0;
            opcode     <= 1'($urandom_range(0, 1));
            sample     <= $urandom();
            bin_select <= 16'($urandom());
        end
    end

    // Monitor: check each result word, then pick the next pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (due_results.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                n_checked++;
                if (sample_counted !== want.counted)
                begin
                    $error("sample_counted: expected %0d, got %0d", want.counted, sample_counted);
                    errors++;
                end
                if (bin_hit !== want.bin)
                begin
                    $error("bin_hit: expected %0d, got %0d", want.bin, bin_hit);
                    errors++;
                end
                if (read_valid !== want.valid)
                begin
                    $error("read_valid: expected %0d, got %0d", want.valid, read_valid);
                    errors++;
                end
                if (bin_value !== want.value)
                begin
                    $error("bin_value: expected %0d, got %0d", want.value, bin_value);
                    errors++;
                end
                if (total_counted !== want.total)
                begin
                    $error("total_counted: expected %0d, got %0d", want.total, total_counted);
                    errors++;
                end
            end
        end

        // Start a long hold-off now and then so the input side backs up
        if (hold_left == 0 && n_checked >= next_hold_at)
        begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 180;
            n_holds++;
        end

        // Periodically pick a new stall pattern
        rx_tick++;
        if (rx_tick % 48 == 0)
            rx_mode = $urandom_range(0, 3);

        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= (rx_tick % 3 == 0);
                default: pop <= ($urandom_range(0, 5) == 0);
            endcase
        end
        rx_holding <= (hold_left > 0);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d words still expected",
                     cycle_count, due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_add(input logic [frh_pkg::SAMPLE_BITS-1:0] value);
        hist_word_t w;
        w.op     = frh_pkg::OP_ADD;
        w.sample = value;
        w.sel    = 16'($urandom());
        stim_words.push_back(w);
    endtask

    task automatic queue_read(input logic [frh_pkg::SELECT_BITS-1:0] idx);
        hist_word_t w;
        w.op     = frh_pkg::OP_READ;
        w.sample = $urandom();
        w.sel    = idx;
        stim_words.push_back(w);
    endtask

    // Wait until every queued word is sent and every result has come back
    task automatic drain();
        while (stim_words.size() != 0 || due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [frh_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [frh_pkg::SAMPLE_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == frh_pkg::REG_RANGE_LOW)
            lo_edge = {{32{data[frh_pkg::SAMPLE_BITS-1]}}, data};
        else
            hi_edge = {{32{data[frh_pkg::SAMPLE_BITS-1]}}, data};
        n_cfg_writes++;
    endtask

    // Stimulus
    initial
    begin
        int          p;
        int          i;
        int          k;
        logic [63:0] rnd;
        logic [63:0] span;
        longint      lo;
        longint      hi;
        longint      x;

        rst_n        = 1'b0;
        push         = 1'b0;
        opcode       = frh_pkg::OP_ADD;
        sample       = '0;
        bin_select   = '0;
        pop          = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = frh_pkg::REG_RANGE_LOW;
        cfg_data     = '0;
        rx_holding   = 1'b0;
        burst_left   = 8;
        gap_left     = 0;
        hold_left    = 0;
        next_hold_at = 100;
        rx_mode      = 0;
        lo_edge      = 0;
        hi_edge      = 65536;
        tally_total  = '0;
        for (i = 0; i < TB_BINS; i++)
            tally[i] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset range [0, 1.0): edges, drops, extremes, valid and invalid reads
        queue_read(16'd0);
        queue_add(32'h0000_0000);
        queue_add(32'h0000_FFFF);
        queue_add(32'h0001_0000);
        queue_add(32'hFFFF_FFFF);
        queue_add(32'h8000_0000);
        queue_add(32'h7FFF_FFFF);
        queue_add(32'h0000_8000);
        queue_read(16'd0);
        queue_read(16'(TB_BINS - 1));
        queue_read(16'(TB_BINS / 2));
        queue_read(16'(TB_BINS));
        queue_read(16'hFFFF);
        drain();

        // Empty range, then inverted range: everything drops
        write_reg(frh_pkg::REG_RANGE_HIGH, 32'h0000_0000);
        queue_add(32'h0000_0000);
        queue_add(32'hFFFF_FFFF);
        drain();
        write_reg(frh_pkg::REG_RANGE_LOW, 32'h0000_0100);
        queue_add(32'h0000_0080);
        drain();

        // Widest range
        write_reg(frh_pkg::REG_RANGE_LOW, 32'h8000_0000);
        write_reg(frh_pkg::REG_RANGE_HIGH, 32'h7FFF_FFFF);
        queue_add(32'h8000_0000);
        queue_add(32'h7FFF_FFFE);
        queue_add(32'h7FFF_FFFF);
        queue_add(32'h0000_0000);
        queue_read(16'd0);
        queue_read(16'(TB_BINS - 1));
        drain();

        // Random phases, each with a fresh range
        for (p = 0; p < RAND_PHASES; p++)
        begin
            rnd = {$urandom(), $urandom()};
            case (p % 4)
                0: span = 64'd1 + rnd % 64;
                1: span = 64'd1 + rnd % 64'h10_0000;
                2: span = 64'd1 + rnd % 64'h8000_0000;
                default: span = 64'hFFFF_FFFF - rnd % 16;
            endcase
            rnd = {$urandom(), $urandom()};
            lo  = longint'(rnd % (64'h1_0000_0000 - span)) + Q_MIN;
            hi  = lo + longint'(span);
            write_reg(frh_pkg::REG_RANGE_LOW, lo[31:0]);
            write_reg(frh_pkg::REG_RANGE_HIGH, hi[31:0]);

            for (i = 0; i < PHASE_WORDS; i++)
            begin
                k   = $urandom_range(0, 99);
                rnd = {$urandom(), $urandom()};
                if (k < 55)
                begin
                    x = lo + longint'(rnd % span);
                    queue_add(x[31:0]);
                end
                else if (k < 63)
                begin
                    case ($urandom_range(0, 3))
                        0: x = lo;
                        1: x = hi - 1;
                        2: x = hi;
                        default: x = lo - 1;
                    endcase
                    queue_add(x[31:0]);
                end
                else if (k < 70)
                    queue_add(rnd[31:0]);
                else if (k < 90)
                    queue_read(16'($urandom_range(0, TB_BINS - 1)));
                else if (k < 95)
                    queue_read(16'($urandom_range(TB_BINS - 2, TB_BINS + 1)));
                else
                    queue_read(rnd[15:0]);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d result words: %0d adds (%0d dropped), %0d reads (%0d out of range)",
                 n_checked, n_add, n_drop, n_read, n_bad_read);
        $display("%0d range writes, %0d receiver hold-offs, %0d cycles with input stalled by full",
                 n_cfg_writes, n_holds, n_full_stalls);
        if (errors == 0 && due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
